@@ hw/rtl/rpe_pkg.sv @@
// ----------------------------------------------------------------------------
// Random permutation engine package
// Payload types, request codes, register indexes and generator constants.
// ----------------------------------------------------------------------------
`default_nettype none

package rpe_pkg;

  localparam logic [1:0] REQ_WRITE   = 2'd0;
  localparam logic [1:0] REQ_SHUFFLE = 2'd1;
  localparam logic [1:0] REQ_READ    = 2'd2;

  localparam int CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] CFG_START_SEED   = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_TABLE_LENGTH = 1'd1;

  localparam int CFG_DATA_W = 64;
  localparam int LENGTH_W   = 11;

  localparam logic [63:0] GOLDEN_GAMMA = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] MIX_MUL_A    = 64'hBF58476D1CE4E5B9;
  localparam logic [63:0] MIX_MUL_B    = 64'h94D049BB133111EB;
  localparam int SHIFT_A = 30;
  localparam int SHIFT_B = 27;
  localparam int SHIFT_C = 31;

  localparam int DIV_BITS   = 4;
  localparam int DIV_STEPS  = 64 / DIV_BITS;
  localparam int DIV_CNT_W  = 4;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [9:0]  entry_index;
    logic [31:0] entry_value;
  } req_item_t;

  typedef struct packed {
    logic [31:0] read_value;
    logic        status;
  } rsp_item_t;

endpackage

`default_nettype wire

@@ hw/rtl/random_permutation_engine_core.sv @@
// ----------------------------------------------------------------------------
// Random permutation engine core
// Table of 32-bit entries in a synchronous memory with write, read and a
// seeded Fisher-Yates shuffle driven by a SplitMix64 generator.
// ----------------------------------------------------------------------------
// Requests arrive on the req channel and each gives exactly one transfer on
// the rsp channel; configuration is to be written through the cfg port only
// while idle, and the block does not enforce this. A write, a shuffle of
// fewer than two entries or an unused code is answered through the output
// register, and a read, in range or not, through the memory read register and
// then the output register.
// A shuffle walks the table from the last position down. Each step advances
// the generator, runs two 64-bit multiplies on one shared 32x32 multiplier,
// reduces the output modulo the position plus one with a 4-bit per cycle
// divider, and swaps the two entries by reading both, then writing each.
// The request channel stalls while a request is in progress. A finished
// result waits in the output register; when that register is full and
// stalled, the next result is held and the request channel stalls.
// Reset clears the control state, rsp_valid, gen and start_seed, and sets
// table_length to 1024; the table contents are undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module random_permutation_engine_core #(
  parameter int TABLE_DEPTH = 1024
) (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 req_valid,
  output logic                                req_stall,
  input  rpe_pkg::req_item_t                  req,
  output logic                                rsp_valid,
  input  wire                                 rsp_stall,
  output rpe_pkg::rsp_item_t                  rsp,
  input  wire                                 cfg_write,
  input  wire  [rpe_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire  [rpe_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int AW   = $clog2(TABLE_DEPTH);
  localparam int LENW = $clog2(TABLE_DEPTH + 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RDATA = 4'd1;
  localparam logic [3:0] S_RESP  = 4'd2;
  localparam logic [3:0] S_ADV   = 4'd3;
  localparam logic [3:0] S_MUL1  = 4'd4;
  localparam logic [3:0] S_MUL2  = 4'd5;
  localparam logic [3:0] S_DIV   = 4'd6;
  localparam logic [3:0] S_RDSW  = 4'd7;
  localparam logic [3:0] S_WR1   = 4'd8;
  localparam logic [3:0] S_WR2   = 4'd9;

  logic [3:0]                      state;
  logic [63:0]                     start_seed;
  logic [rpe_pkg::LENGTH_W-1:0]    table_length;
  logic [63:0]                     gen;
  logic [63:0]                     gen_sum;
  logic [63:0]                     z;
  logic [63:0]                     acc;
  logic [63:0]                     prod_q;
  logic [1:0]                      mcnt;
  logic [63:0]                     q;
  logic [LENW-1:0]                 r;
  logic [LENW-1:0]                 r_next;
  logic [LENW:0]                   div_sh;
  logic [LENW-1:0]                 divisor;
  logic [rpe_pkg::DIV_CNT_W-1:0]   dcnt;
  logic [AW-1:0]                   pos;
  logic [AW-1:0]                   oth;
  logic                            rd_err;
  rpe_pkg::rsp_item_t              res_q;

  logic [LENW-1:0]                 eff_len;
  logic                            idx_ok;
  logic                            req_acc;
  logic                            out_free;
  logic                            fin_valid;
  rpe_pkg::rsp_item_t              fin_item;

  logic [31:0]                     mem [TABLE_DEPTH];
  logic [31:0]                     rd_a;
  logic [31:0]                     rd_b;
  logic                            we;
  logic [AW-1:0]                   waddr;
  logic [31:0]                     wdata;
  logic                            re_a;
  logic                            re_b;
  logic [AW-1:0]                   raddr_a;
  logic [AW-1:0]                   raddr_b;

  logic [63:0]                     mul_k;
  logic [31:0]                     mul_a;
  logic [31:0]                     mul_b;
  logic [63:0]                     mul_fin;

  assign eff_len  = (32'(table_length) > 32'(TABLE_DEPTH)) ? LENW'(TABLE_DEPTH)
                                                           : LENW'(table_length);
  assign idx_ok   = 32'(req.entry_index) < 32'(eff_len);
  assign req_stall = (state != S_IDLE);
  assign req_acc  = req_valid && (state == S_IDLE);
  assign out_free = !rsp_valid || !rsp_stall;
  assign gen_sum  = gen + rpe_pkg::GOLDEN_GAMMA;

  always_comb begin
    fin_valid = 1'b0;
    fin_item  = '0;
    unique case (state)
      S_IDLE: begin
        if (req_valid && (req.req_type != rpe_pkg::REQ_READ) &&
            !((req.req_type == rpe_pkg::REQ_SHUFFLE) && (eff_len >= LENW'(2)))) begin
          fin_valid       = 1'b1;
          fin_item.status = (req.req_type == rpe_pkg::REQ_WRITE) && !idx_ok;
        end
      end
      S_RDATA: begin
        fin_valid = 1'b1;
        if (rd_err) begin
          fin_item.status = 1'b1;
        end else begin
          fin_item.read_value = rd_a;
        end
      end
      S_RESP: begin
        fin_valid = 1'b1;
        fin_item  = res_q;
      end
      S_WR2: begin
        fin_valid = (pos == AW'(1));
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    we      = 1'b0;
    waddr   = pos;
    wdata   = rd_b;
    re_a    = 1'b0;
    re_b    = 1'b0;
    raddr_a = pos;
    raddr_b = oth;
    unique case (state)
      S_IDLE: begin
        waddr   = AW'(req.entry_index);
        wdata   = req.entry_value;
        raddr_a = AW'(req.entry_index);
        we      = req_acc && (req.req_type == rpe_pkg::REQ_WRITE) && idx_ok;
        re_a    = req_acc && (req.req_type == rpe_pkg::REQ_READ);
      end
      S_RDSW: begin
        re_a = 1'b1;
        re_b = 1'b1;
      end
      S_WR1: begin
        we = 1'b1;
      end
      S_WR2: begin
        we    = 1'b1;
        waddr = oth;
        wdata = rd_a;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re_a) begin
      rd_a <= mem[raddr_a];
    end
    if (re_b) begin
      rd_b <= mem[raddr_b];
    end
  end

  // The low 64 bits of a 64x64 product need three 32x32 partial products.
  assign mul_k   = (state == S_MUL1) ? rpe_pkg::MIX_MUL_A : rpe_pkg::MIX_MUL_B;
  assign mul_a   = (mcnt == 2'd2) ? z[63:32] : z[31:0];
  assign mul_b   = (mcnt == 2'd1) ? mul_k[63:32] : mul_k[31:0];
  assign mul_fin = {acc[63:32] + prod_q[31:0], acc[31:0]};

  assign divisor = LENW'(pos) + LENW'(1);

  always_comb begin
    r_next = r;
    div_sh = '0;
    for (int j = 0; j < rpe_pkg::DIV_BITS; j++) begin
      div_sh = {r_next, q[63-j]};
      if (div_sh >= {1'b0, divisor}) begin
        r_next = LENW'(div_sh - {1'b0, divisor});
      end else begin
        r_next = LENW'(div_sh);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      rsp_valid    <= 1'b0;
      gen          <= '0;
      start_seed   <= '0;
      table_length <= rpe_pkg::LENGTH_W'(1024);
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          rpe_pkg::CFG_START_SEED:   start_seed   <= cfg_data;
          rpe_pkg::CFG_TABLE_LENGTH: table_length <= cfg_data[rpe_pkg::LENGTH_W-1:0];
          default: begin
          end
        endcase
      end

      if (fin_valid && out_free) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            if (req.req_type == rpe_pkg::REQ_SHUFFLE) begin
              gen <= start_seed;
            end
            if (fin_valid) begin
              state <= out_free ? S_IDLE : S_RESP;
            end else if (req.req_type == rpe_pkg::REQ_READ) begin
              state <= S_RDATA;
            end else begin
              state <= S_ADV;
            end
          end
        end
        S_RDATA, S_RESP: begin
          state <= out_free ? S_IDLE : S_RESP;
        end
        S_ADV: begin
          gen   <= gen_sum;
          state <= S_MUL1;
        end
        S_MUL1: begin
          if (mcnt == 2'd3) begin
            state <= S_MUL2;
          end
        end
        S_MUL2: begin
          if (mcnt == 2'd3) begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (dcnt == rpe_pkg::DIV_CNT_W'(rpe_pkg::DIV_STEPS - 1)) begin
            state <= S_RDSW;
          end
        end
        S_RDSW: begin
          state <= S_WR1;
        end
        S_WR1: begin
          state <= S_WR2;
        end
        S_WR2: begin
          if (fin_valid) begin
            state <= out_free ? S_IDLE : S_RESP;
          end else begin
            state <= S_ADV;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (fin_valid && out_free) begin
      rsp <= fin_item;
    end
    if (fin_valid) begin
      res_q <= fin_item;
    end
    unique case (state)
      S_IDLE: begin
        rd_err <= !idx_ok;
        pos    <= AW'(eff_len - LENW'(1));
      end
      S_ADV: begin
        z    <= gen_sum ^ (gen_sum >> rpe_pkg::SHIFT_A);
        mcnt <= 2'd0;
      end
      S_MUL1, S_MUL2: begin
        prod_q <= 64'(mul_a) * 64'(mul_b);
        mcnt   <= mcnt + 2'd1;
        if (mcnt == 2'd1) begin
          acc <= prod_q;
        end else if (mcnt == 2'd2) begin
          acc[63:32] <= acc[63:32] + prod_q[31:0];
        end
        if (mcnt == 2'd3) begin
          if (state == S_MUL1) begin
            z <= mul_fin ^ (mul_fin >> rpe_pkg::SHIFT_B);
          end else begin
            q    <= mul_fin ^ (mul_fin >> rpe_pkg::SHIFT_C);
            r    <= '0;
            dcnt <= '0;
          end
        end
      end
      S_DIV: begin
        r    <= r_next;
        q    <= q << rpe_pkg::DIV_BITS;
        dcnt <= dcnt + rpe_pkg::DIV_CNT_W'(1);
        oth  <= AW'(r_next);
      end
      S_WR2: begin
        pos <= pos - AW'(1);
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire
